### src/irz_pkg.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler package
// Shared types, command and result codes, and default values.
// ----------------------------------------------------------------------------
package irz_pkg;

   // Days in one weekly table.
   localparam int DAYS = 7;

   // Default configuration values.
   localparam int DEF_ZONES = 4;
   localparam int DEF_SLOTS = 4;
   localparam int DEF_RAIN_TENTHS = 50;

   // Millisecond count of one minute.
   localparam logic [31:0] MS_PER_MIN = 32'd60000;

   // Reset contents of a slot entry.
   localparam logic [4:0]  RST_HOUR = 5'd6;
   localparam logic [5:0]  RST_MIN = 6'd30;
   localparam logic [5:0]  RST_MIN_IVL = 6'd35;
   localparam logic [15:0] RST_DUR = 16'd5;
   localparam logic [7:0]  RST_IVL_DAYS = 8'd2;
   localparam logic [7:0]  RST_IVL_DAYS_Z1 = 8'd3;

   // Command codes.
   localparam logic [2:0] CMD_TIME = 3'd0;
   localparam logic [2:0] CMD_DAY_SLOT = 3'd1;
   localparam logic [2:0] CMD_IVL_SLOT = 3'd2;
   localparam logic [2:0] CMD_ZONE_SET = 3'd3;
   localparam logic [2:0] CMD_FORCE = 3'd4;

   // Relay change codes.
   localparam logic [1:0] CHG_NONE = 2'd0;
   localparam logic [1:0] CHG_ON = 2'd1;
   localparam logic [1:0] CHG_OFF = 2'd2;

   // Reason codes.
   localparam logic [2:0] RSN_WAIT = 3'd0;
   localparam logic [2:0] RSN_NO_DAY = 3'd1;
   localparam logic [2:0] RSN_RAIN = 3'd2;
   localparam logic [2:0] RSN_FORCED = 3'd3;
   localparam logic [2:0] RSN_SCHED = 3'd4;

   // One slot table entry.
   typedef struct packed {
      logic [4:0]  hr;
      logic [5:0]  mn;
      logic [15:0] dur;
      logic        en;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_OUT
   } state_type;

endpackage

### src/irz_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irz_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/irrigation_zone_scheduler_top.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler
// Multi-zone watering timer with weekday and interval slot tables in RAM.
// ----------------------------------------------------------------------------
// A time update beat (cmd 0 with a known hour and minute) yields one result
// beat per zone, in zone order, with last set on the final one. For an idle
// zone the slot table RAM is read one entry a cycle, then the drain state
// drains the read, the decide state decides the zone and the output state
// presents the result until it is taken. A running zone reads only its own
// entry. Write commands give no result. After reset the slot tables are
// loaded with their default entries by a clearing pass, during which no beat
// is accepted. The block takes one item at a time.
module irrigation_zone_scheduler_top
   import irz_pkg::*;
#(
   parameter int ZONES = DEF_ZONES,
   parameter int SLOTS = DEF_SLOTS,
   parameter int DEFAULT_RAIN_TENTHS = DEF_RAIN_TENTHS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [1:0]  req_zone,
   input  logic [2:0]  req_day,
   input  logic [1:0]  req_slot,
   input  logic signed [5:0] req_hour,
   input  logic signed [6:0] req_minute,
   input  logic [15:0] req_value,
   input  logic        req_flag,
   input  logic [31:0] req_epoch_day,
   input  logic [15:0] req_rain_tenth_mm,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_zone,
   output logic [1:0]  rsp_relay_change,
   output logic        rsp_zone_running,
   output logic [2:0]  rsp_reason,
   output logic        rsp_last
);

   localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DDEPTH = ZONES * DAYS * SLOTS;
   localparam int IDEPTH = ZONES * SLOTS;
   localparam int DAW = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
   localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

   // Sequencer.
   state_type state_ff, state_in;

   // Per-zone settings and run state.
   logic        mode_ff   [ZONES];
   logic [7:0]  ivd_ff    [ZONES];
   logic [31:0] lwd_ff    [ZONES];
   logic [15:0] thr_ff    [ZONES];
   logic        force_ff  [ZONES];
   logic        run_ff    [ZONES];
   logic [31:0] start_ff  [ZONES];
   logic [2:0]  rday_ff   [ZONES];
   logic [SW-1:0] rslot_ff [ZONES];
   logic [2:0]  reason_ff [ZONES];
   logic [10:0] last_min_ff;

   // Latched update beat.
   logic [31:0] now_ff;
   logic [31:0] eday_ff;
   logic [15:0] rain_ff;
   logic [10:0] cur_ff;
   logic [2:0]  didx_ff;
   logic        newmin_ff;

   // Walk counters and scan results.
   logic [ZW-1:0]  zc_ff;
   logic [SW-1:0]  sc_ff;
   logic [DAW-1:0] clr_ff;
   logic           rd_vld_ff;
   logic [SW-1:0]  rd_slot_ff;
   logic           any_en_ff;
   logic           hit_ff;
   logic [SW-1:0]  hit_slot_ff;
   logic [31:0]    dur_ms_ff;

   // Result register.
   logic [1:0] out_chg_ff;
   logic       out_run_ff;
   logic [2:0] out_rsn_ff;

   // RAM ports.
   logic           d_we, i_we;
   logic [DAW-1:0] d_waddr, d_raddr;
   logic [IAW-1:0] i_waddr, i_raddr;
   slot_type       d_wdata, i_wdata, d_q, i_q, q;

   // Decoded request.
   logic          acc;
   logic          zone_ok, slot_ok, day_ok_w;
   logic          time_ok;
   logic [ZW-1:0] wz;
   logic [SW-1:0] ws;
   logic [10:0]   cur_w;
   logic [2:0]    didx_w;
   slot_type      wslot;

   // Scan address and slot match.
   logic          zrun;
   logic [SW-1:0] rs;
   logic [2:0]    rd_day;
   logic [10:0]   sm;
   logic          last_zone;

   // Zone decision.
   logic day_ok;
   logic elapsed_done;

   assign acc = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Decode the request beat.
   always_comb begin
      zone_ok = (32'(req_zone) < ZONES);
      slot_ok = (32'(req_slot) < SLOTS);
      day_ok_w = (32'(req_day) < DAYS);
      time_ok = !req_hour[5] && !req_minute[6];
      wz = ZW'(req_zone);
      ws = SW'(req_slot);
      cur_w = 11'(req_hour[4:0]) * 11'd60 + 11'(req_minute[5:0]);
      didx_w = (req_day == 3'd0 || req_day == 3'd7) ? 3'd6 : req_day - 3'd1;
      wslot.hr = req_hour[4:0];
      wslot.mn = req_minute[5:0];
      wslot.dur = req_value;
      wslot.en = req_flag;
   end

   // RAM write ports: clearing pass after reset, slot writes when idle.
   always_comb begin
      d_we = 1'b0;
      i_we = 1'b0;
      d_waddr = DAW'((32'(wz) * DAYS + 32'(req_day)) * SLOTS + 32'(ws));
      i_waddr = IAW'(32'(wz) * SLOTS + 32'(ws));
      d_wdata = wslot;
      i_wdata = wslot;
      if (state_ff == ST_CLEAR) begin
         d_we = 1'b1;
         d_waddr = clr_ff;
         d_wdata.hr = RST_HOUR;
         d_wdata.mn = RST_MIN;
         d_wdata.dur = RST_DUR;
         d_wdata.en = (32'(clr_ff) == 0) || (32'(clr_ff) == 2 * SLOTS) ||
                      (32'(clr_ff) == 4 * SLOTS);
         i_we = (32'(clr_ff) < IDEPTH);
         i_waddr = IAW'(clr_ff);
         i_wdata.hr = RST_HOUR;
         i_wdata.dur = RST_DUR;
         if (ZONES > 1 && 32'(clr_ff) == SLOTS) begin
            i_wdata.mn = RST_MIN_IVL;
            i_wdata.en = 1'b1;
         end else begin
            i_wdata.mn = RST_MIN;
            i_wdata.en = 1'b0;
         end
      end else if (acc && zone_ok && slot_ok) begin
         d_we = (req_cmd == CMD_DAY_SLOT) && day_ok_w;
         i_we = (req_cmd == CMD_IVL_SLOT);
      end
   end

   // Read address of the zone walk.
   always_comb begin
      zrun = run_ff[zc_ff];
      rs = zrun ? rslot_ff[zc_ff] : sc_ff;
      rd_day = zrun ? rday_ff[zc_ff] : didx_ff;
      d_raddr = DAW'((32'(zc_ff) * DAYS + 32'(rd_day)) * SLOTS + 32'(rs));
      i_raddr = IAW'(32'(zc_ff) * SLOTS + 32'(rs));
      q = mode_ff[zc_ff] ? i_q : d_q;
      sm = 11'(q.hr) * 11'd60 + 11'(q.mn);
      last_zone = (32'(zc_ff) == ZONES - 1);
   end

   irz_ram #(.WIDTH(SLOT_W), .DEPTH(DDEPTH), .AW(DAW)) u_day_ram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_raddr), .rdata(d_q)
   );

   irz_ram #(.WIDTH(SLOT_W), .DEPTH(IDEPTH), .AW(IAW)) u_ivl_ram (
      .clock(clock), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
      .raddr(i_raddr), .rdata(i_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (32'(clr_ff) == DDEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc && req_cmd == CMD_TIME && time_ok) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (zrun || 32'(sc_ff) == SLOTS - 1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = last_zone ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Zone decision terms.
   always_comb begin
      day_ok = mode_ff[zc_ff] ?
               (lwd_ff[zc_ff] == 32'd0 ||
                (eday_ff - lwd_ff[zc_ff]) >= 32'(ivd_ff[zc_ff])) :
               any_en_ff;
      elapsed_done = (now_ff - start_ff[zc_ff]) >= dur_ms_ff;
   end

   // Walk counters, scan accumulation and the latched update beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         zc_ff <= '0;
         sc_ff <= '0;
         rd_vld_ff <= 1'b0;
         last_min_ff <= 11'h7FF;
      end else begin
         rd_vld_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_IDLE && state_in == ST_SCAN) begin
            last_min_ff <= cur_w;
            zc_ff <= '0;
         end else if (state_ff == ST_OUT && state_in == ST_SCAN) begin
            zc_ff <= zc_ff + 1'b1;
         end
         if (state_ff == ST_SCAN) begin
            sc_ff <= sc_ff + 1'b1;
         end else begin
            sc_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= rs;
      if (state_ff == ST_IDLE) begin
         now_ff <= req_now_ms;
         eday_ff <= req_epoch_day;
         rain_ff <= req_rain_tenth_mm;
         cur_ff <= cur_w;
         didx_ff <= didx_w;
         newmin_ff <= (cur_w != last_min_ff);
      end
      if (state_ff != ST_SCAN && state_in == ST_SCAN) begin
         any_en_ff <= 1'b0;
         hit_ff <= 1'b0;
         hit_slot_ff <= '0;
      end else if (rd_vld_ff) begin
         dur_ms_ff <= 32'(q.dur) * MS_PER_MIN;
         if (q.en) begin
            any_en_ff <= 1'b1;
         end
         if (q.en && !hit_ff && sm == cur_ff && newmin_ff) begin
            hit_ff <= 1'b1;
            hit_slot_ff <= rd_slot_ff;
         end
      end
   end

   // Per-zone state: writes when idle, decision once per zone.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            mode_ff[z] <= (z == 1);
            ivd_ff[z] <= (z == 1) ? RST_IVL_DAYS_Z1 : RST_IVL_DAYS;
            lwd_ff[z] <= '0;
            thr_ff[z] <= 16'(DEFAULT_RAIN_TENTHS);
            force_ff[z] <= 1'b0;
            run_ff[z] <= 1'b0;
            start_ff[z] <= '0;
            rday_ff[z] <= '0;
            rslot_ff[z] <= '0;
            reason_ff[z] <= RSN_WAIT;
         end
      end else if (acc && zone_ok) begin
         if (req_cmd == CMD_ZONE_SET) begin
            mode_ff[wz] <= req_flag;
            ivd_ff[wz] <= req_value[7:0];
            thr_ff[wz] <= req_rain_tenth_mm;
         end else if (req_cmd == CMD_FORCE) begin
            force_ff[wz] <= req_flag;
         end
      end else if (state_ff == ST_DECIDE) begin
         if (run_ff[zc_ff]) begin
            if (elapsed_done) begin
               run_ff[zc_ff] <= 1'b0;
               start_ff[zc_ff] <= '0;
            end
         end else if (!day_ok) begin
            reason_ff[zc_ff] <= RSN_NO_DAY;
         end else if (!force_ff[zc_ff] && rain_ff >= thr_ff[zc_ff]) begin
            reason_ff[zc_ff] <= RSN_RAIN;
         end else begin
            reason_ff[zc_ff] <= force_ff[zc_ff] ? RSN_FORCED : RSN_SCHED;
            if (hit_ff) begin
               run_ff[zc_ff] <= 1'b1;
               start_ff[zc_ff] <= now_ff;
               rday_ff[zc_ff] <= didx_ff;
               rslot_ff[zc_ff] <= hit_slot_ff;
               force_ff[zc_ff] <= 1'b0;
               if (mode_ff[zc_ff]) begin
                  lwd_ff[zc_ff] <= eday_ff;
               end
            end
         end
      end
   end

   // Result register, loaded with the zone's outcome.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         out_chg_ff <= CHG_NONE;
         out_run_ff <= run_ff[zc_ff];
         out_rsn_ff <= reason_ff[zc_ff];
         if (run_ff[zc_ff]) begin
            if (elapsed_done) begin
               out_chg_ff <= CHG_OFF;
               out_run_ff <= 1'b0;
            end
         end else if (!day_ok) begin
            out_rsn_ff <= RSN_NO_DAY;
         end else if (!force_ff[zc_ff] && rain_ff >= thr_ff[zc_ff]) begin
            out_rsn_ff <= RSN_RAIN;
         end else begin
            out_rsn_ff <= force_ff[zc_ff] ? RSN_FORCED : RSN_SCHED;
            if (hit_ff) begin
               out_chg_ff <= CHG_ON;
               out_run_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_out_zone = 2'(zc_ff);
   assign rsp_relay_change = out_chg_ff;
   assign rsp_zone_running = out_run_ff;
   assign rsp_reason = out_rsn_ff;
   assign rsp_last = last_zone;

endmodule

### src/irz_checker.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module irz_checker
   import irz_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_out_zone,
   input logic [1:0] rsp_relay_change,
   input logic       rsp_zone_running,
   input logic [2:0] rsp_reason,
   input logic       rsp_last
);

   // A stalled result beat holds its zone, relay change, reason and last flag.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_zone) &&
      $stable(rsp_relay_change) && $stable(rsp_reason) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // No new item is taken while results are pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

   // A zone switched on is running and has a forced or scheduled reason.
   a_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relay_change == CHG_ON |->
      rsp_zone_running && (rsp_reason == RSN_FORCED || rsp_reason == RSN_SCHED))
      else $error("switch-on result inconsistent");

   // A zone switched off is not running.
   a_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relay_change == CHG_OFF |-> !rsp_zone_running)
      else $error("switch-off result still running");

endmodule

bind irrigation_zone_scheduler_top irz_checker u_irz_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_out_zone(rsp_out_zone),
   .rsp_relay_change(rsp_relay_change),
   .rsp_zone_running(rsp_zone_running),
   .rsp_reason(rsp_reason),
   .rsp_last(rsp_last)
);
